>>> hdl/cgp_pkg.sv
// Package for the sparse graph permutation block.
// Holds sizes, operation codes, controller states and the command and status structs.
// No dependencies.
package cgp_pkg;

    localparam int MAX_VERTICES    = 1024;
    localparam int VTX_W           = 10;
    localparam int OFFS_AW         = 11;
    localparam int MAX_ENTRIES     = 8192;
    localparam int ENT_W           = 13;
    localparam int OFFS_W          = 14;
    localparam int COLUMN_BITS     = 20;
    localparam int MAX_ROW_RESULTS = 64;
    localparam int K_W             = 7;
    localparam int VCNT_W          = 11;
    localparam int WHI_W           = 21;
    localparam int CFG_DATA_W      = 21;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [2:0] {
        OP_WR_OFFSET = 3'd0,
        OP_WR_COLUMN = 3'd1,
        OP_WR_PERM   = 3'd2,
        OP_WR_INV    = 3'd3,
        OP_EMIT      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_PERMUTE_MODE = 2'd1,
        CFG_WINDOW_LOW   = 2'd2,
        CFG_WINDOW_HIGH  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_FULL   = 2'd0,
        MODE_ROWS   = 2'd1,
        MODE_COLS   = 2'd2,
        MODE_WINDOW = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_OLDROW,
        ST_OFFS,
        ST_BOUNDS,
        ST_EMPTY,
        ST_COLRD,
        ST_REMAP,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic do_write;
        logic rd_iperm;
        logic set_old;
        logic rd_offs;
        logic set_bounds;
        logic rd_col;
        logic rd_perm;
        logic load_out;
        logic load_empty;
    } t_cmd;

    typedef struct packed {
        logic emit_ok;
        logic len_zero;
        logic out_free;
        logic k_last;
    } t_status;

endpackage

>>> hdl/cgp_in_if.sv
// Input channel interface of the sparse graph permutation block.
// Carries valid, ready and the input fields; sizes come from cgp_pkg.
interface cgp_in_if;
    import cgp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [2:0]             operation;
    logic [OFFS_W-1:0]      index;
    logic [COLUMN_BITS-1:0] value;
    modport source (output valid, operation, index, value, input ready);
    modport sink (input valid, operation, index, value, output ready);
endinterface

>>> hdl/cgp_out_if.sv
// Result channel interface of the sparse graph permutation block.
// Carries valid, ready and the result fields; sizes come from cgp_pkg.
interface cgp_out_if;
    import cgp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [COLUMN_BITS-1:0] column;
    logic [ENT_W-1:0]       position;
    logic [OFFS_W-1:0]      row_start;
    logic                   empty_row;
    logic                   truncated;
    logic                   last;
    modport source (output valid, column, position, row_start, empty_row, truncated, last,
                    input ready);
    modport sink (input valid, column, position, row_start, empty_row, truncated, last,
                  output ready);
endinterface

>>> hdl/csr_graph_permute_top.sv
// Top level of the sparse graph permutation block.
// Joins cgp_ctrl and cgp_datapath; uses cgp_pkg, cgp_in_if and cgp_out_if.
//
// Usage: the input channel i_in takes one transaction per item. Operations 0 to 3
// write row offsets, column ids, the forward permutation or the inverse
// permutation; each write yields no result. Operation 4 emits a new row on
// o_out: one transaction per remapped column, or a single empty-row
// transaction, with last marking the final one of the row; a row index at or
// above the vertex count yields none. An emit does its setup (range check,
// inverse permutation read, row offset read) and then, per entry, a column
// memory read, a permutation memory read and a result register load; at most
// 64 entries per row. Input ready is high only while the controller is idle.
// The result register holds a transaction until it is taken; a stalled
// receiver stalls the row walk but no data is lost. Configuration registers
// are written through i_cfg_we, i_cfg_index and i_cfg_data; the user must
// write them only while the block is idle, the block does not enforce this.
// Reset clears the configuration, running offset and controller, not the graph memories.
module csr_graph_permute_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cgp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cgp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cgp_in_if.sink                         i_in,
    cgp_out_if.source                      o_out
);
    import cgp_pkg::*;

    t_cmd    cmd;
    t_status status;

    cgp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_operation (i_in.operation),
        .o_in_ready     (i_in.ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    cgp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_operation (i_in.operation),
        .i_in_index     (i_in.index),
        .i_in_value     (i_in.value),
        .o_out          (o_out),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

>>> hdl/cgp_ctrl.sv
// Controller state machine of the sparse graph permutation block.
// Sequences writes and row emission through commands to cgp_datapath; uses cgp_pkg.
module cgp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_in_operation,
    output logic             o_in_ready,
    input  cgp_pkg::t_status i_status,
    output cgp_pkg::t_cmd    o_cmd
);
    import cgp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    if (i_in_operation == OP_EMIT) begin
                        n_state = ST_CHECK;
                    end else begin
                        o_cmd.do_write = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.emit_ok) begin
                    o_cmd.rd_iperm = 1'b1;
                    n_state        = ST_OLDROW;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OLDROW: begin
                o_cmd.set_old = 1'b1;
                n_state       = ST_OFFS;
            end
            ST_OFFS: begin
                o_cmd.rd_offs = 1'b1;
                n_state       = ST_BOUNDS;
            end
            ST_BOUNDS: begin
                o_cmd.set_bounds = 1'b1;
                n_state = i_status.len_zero ? ST_EMPTY : ST_COLRD;
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_COLRD: begin
                o_cmd.rd_col = 1'b1;
                n_state      = ST_REMAP;
            end
            ST_REMAP: begin
                o_cmd.rd_perm = 1'b1;
                n_state       = ST_PUT;
            end
            ST_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = i_status.k_last ? ST_IDLE : ST_COLRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cgp_datapath.sv
// Datapath of the sparse graph permutation block: graph memories, configuration
// registers, running offset and the result register. Uses cgp_pkg and cgp_out_if.
module cgp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cgp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cgp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [2:0]                         i_in_operation,
    input  logic [cgp_pkg::OFFS_W-1:0]         i_in_index,
    input  logic [cgp_pkg::COLUMN_BITS-1:0]    i_in_value,
    cgp_out_if.source                          o_out,
    input  cgp_pkg::t_cmd                      i_cmd,
    output cgp_pkg::t_status                   o_status
);
    import cgp_pkg::*;

    logic [OFFS_W-1:0]      m_offs [0:MAX_VERTICES];
    logic [COLUMN_BITS-1:0] m_col  [0:MAX_ENTRIES-1];
    logic [COLUMN_BITS-1:0] m_perm [0:MAX_VERTICES-1];
    logic [COLUMN_BITS-1:0] m_inv  [0:MAX_VERTICES-1];

    logic [VCNT_W-1:0]      r_vcount;
    logic [1:0]             r_mode;
    logic [COLUMN_BITS-1:0] r_wlo;
    logic [WHI_W-1:0]       r_whi;

    logic [2:0]             r_op;
    logic [OFFS_W-1:0]      r_idx;
    logic [OFFS_W-1:0]      r_start;
    logic [OFFS_W-1:0]      r_run;
    logic [COLUMN_BITS-1:0] r_inv_q;
    logic [COLUMN_BITS-1:0] r_old;
    logic                   r_old_ok;
    logic [OFFS_W-1:0]      r_lo_q;
    logic [OFFS_W-1:0]      r_hi_q;
    logic [COLUMN_BITS-1:0] r_col_q;
    logic [COLUMN_BITS-1:0] r_perm_q;
    logic [COLUMN_BITS-1:0] r_c;
    logic                   r_use;
    logic [ENT_W-1:0]       r_j;
    logic [K_W-1:0]         r_k;
    logic [K_W-1:0]         r_emit;
    logic                   r_trunc;

    logic                   r_out_valid;
    logic [COLUMN_BITS-1:0] r_o_col;
    logic [ENT_W-1:0]       r_o_pos;
    logic [OFFS_W-1:0]      r_o_start;
    logic                   r_o_empty;
    logic                   r_o_trunc;
    logic                   r_o_last;

    logic [VCNT_W-1:0]      n_count;
    logic [COLUMN_BITS-1:0] old_row;
    logic [OFFS_AW-1:0]     offs_addr;
    logic [OFFS_W-1:0]      len;
    logic [OFFS_W:0]        run_sum;
    logic [OFFS_W:0]        pos_sum;
    logic [COLUMN_BITS-1:0] win_diff;
    logic                   in_win;
    logic [COLUMN_BITS-1:0] pidx;
    logic                   use_perm;
    logic [OFFS_W-1:0]      wr_offs;

    assign n_count  = (r_vcount > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : r_vcount;
    assign old_row  = (r_mode == MODE_COLS) ? COLUMN_BITS'(r_idx) : r_inv_q;
    assign offs_addr = r_old_ok ? r_old[OFFS_AW-1:0] : '0;
    assign len      = (r_old_ok && (r_hi_q > r_lo_q)) ? (r_hi_q - r_lo_q) : '0;
    assign run_sum  = {1'b0, r_start} + {1'b0, len};
    assign pos_sum  = {1'b0, r_start} + (OFFS_W + 1)'(r_k);
    assign wr_offs  = (i_in_value < COLUMN_BITS'(MAX_ENTRIES)) ?
                      OFFS_W'(i_in_value) : OFFS_W'(MAX_ENTRIES);
    assign win_diff = r_col_q - r_wlo;
    assign in_win   = (r_col_q >= r_wlo) && ({1'b0, r_col_q} < r_whi);

    always_comb begin
        pidx     = r_col_q;
        use_perm = 1'b0;
        case (r_mode)
            MODE_FULL, MODE_COLS: begin
                use_perm = r_col_q < COLUMN_BITS'(MAX_VERTICES);
            end
            MODE_WINDOW: begin
                pidx     = win_diff;
                use_perm = in_win && (win_diff < COLUMN_BITS'(MAX_VERTICES));
            end
            default: begin
                use_perm = 1'b0;
            end
        endcase
    end

    assign o_status.emit_ok  = (r_op == OP_EMIT) && (r_idx < OFFS_W'(n_count));
    assign o_status.len_zero = !r_old_ok || !(r_hi_q > r_lo_q);
    assign o_status.out_free = !r_out_valid || o_out.ready;
    assign o_status.k_last   = (K_W'(r_k + 1'b1) == r_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            r_mode   <= '0;
            r_wlo    <= '0;
            r_whi    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data[VCNT_W-1:0];
                CFG_PERMUTE_MODE: r_mode   <= i_cfg_data[1:0];
                CFG_WINDOW_LOW:   r_wlo    <= i_cfg_data[COLUMN_BITS-1:0];
                CFG_WINDOW_HIGH:  r_whi    <= i_cfg_data[WHI_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            case (i_in_operation)
                OP_WR_OFFSET: begin
                    if (i_in_index <= OFFS_W'(MAX_VERTICES)) begin
                        m_offs[i_in_index[OFFS_AW-1:0]] <= wr_offs;
                    end
                end
                OP_WR_COLUMN: begin
                    if (i_in_index < OFFS_W'(MAX_ENTRIES)) begin
                        m_col[i_in_index[ENT_W-1:0]] <= i_in_value;
                    end
                end
                OP_WR_PERM: begin
                    if (i_in_index < OFFS_W'(MAX_VERTICES)) begin
                        m_perm[i_in_index[VTX_W-1:0]] <= i_in_value;
                    end
                end
                OP_WR_INV: begin
                    if (i_in_index < OFFS_W'(MAX_VERTICES)) begin
                        m_inv[i_in_index[VTX_W-1:0]] <= i_in_value;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.rd_iperm) begin
            r_inv_q <= m_inv[r_idx[VTX_W-1:0]];
        end
        if (i_cmd.rd_offs) begin
            r_lo_q <= m_offs[offs_addr];
            r_hi_q <= m_offs[OFFS_AW'(offs_addr + 1'b1)];
        end
        if (i_cmd.rd_col) begin
            r_col_q <= m_col[r_j];
        end
        if (i_cmd.rd_perm) begin
            r_perm_q <= m_perm[pidx[VTX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_in_operation;
            r_idx <= i_in_index;
        end
        if (i_cmd.rd_iperm) begin
            r_start <= (r_idx == '0) ? '0 : r_run;
        end
        if (i_cmd.set_old) begin
            r_old    <= old_row;
            r_old_ok <= old_row < COLUMN_BITS'(n_count);
        end
        if (i_cmd.set_bounds) begin
            r_j     <= r_lo_q[ENT_W-1:0];
            r_k     <= '0;
            r_trunc <= len > OFFS_W'(MAX_ROW_RESULTS);
            r_emit  <= (len > OFFS_W'(MAX_ROW_RESULTS)) ? K_W'(MAX_ROW_RESULTS) : len[K_W-1:0];
        end
        if (i_cmd.rd_perm) begin
            r_c   <= r_col_q;
            r_use <= use_perm;
        end
        if (i_cmd.load_out) begin
            r_j <= ENT_W'(r_j + 1'b1);
            r_k <= K_W'(r_k + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_cmd.set_bounds) begin
            r_run <= (run_sum > (OFFS_W + 1)'(MAX_ENTRIES)) ?
                     OFFS_W'(MAX_ENTRIES) : run_sum[OFFS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out || i_cmd.load_empty) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_empty) begin
            r_o_col   <= '0;
            r_o_pos   <= '0;
            r_o_start <= r_start;
            r_o_empty <= 1'b1;
            r_o_trunc <= 1'b0;
            r_o_last  <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_o_col   <= r_use ? r_perm_q : r_c;
            r_o_pos   <= (pos_sum >= (OFFS_W + 1)'(MAX_ENTRIES)) ?
                         ENT_W'(MAX_ENTRIES - 1) : pos_sum[ENT_W-1:0];
            r_o_start <= r_start;
            r_o_empty <= 1'b0;
            r_o_trunc <= o_status.k_last && r_trunc;
            r_o_last  <= o_status.k_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.column    = r_o_col;
    assign o_out.position  = r_o_pos;
    assign o_out.row_start = r_o_start;
    assign o_out.empty_row = r_o_empty;
    assign o_out.truncated = r_o_trunc;
    assign o_out.last      = r_o_last;

endmodule
